/* rtl/sfcg_pkg.sv */
// Package for the scaled font character generator.
// Holds the command type passed from front to back, the glyph ROM and the
// pixel stretch function. No dependencies.
package sfcg_pkg;

   localparam int GLYPH_WIDTH = 5;
   localparam int CELL_PITCH  = 6;
   localparam int QDEPTH      = 2;

   // One classified character, ready for column generation
   typedef struct packed {
      logic [39:0] glyph;        // column 0 in bits 39:32
      logic [7:0]  base_column;
      logic [2:0]  page;
      logic [3:0]  span;         // vertical repeat and page count
      logic [3:0]  reps;         // horizontal repeat of each column
      logic        native;       // scale 0: five columns plus blank column
   } sfcg_cmd_type;

   // 128 x 5 glyph ROM, five column bytes per code
   function automatic logic [39:0] font_glyph(input logic [6:0] code);
      logic [39:0] g;
      case (code)
         7'd0:   g = 40'hffffffffff;
         7'd32:  g = 40'h0000000000;
         7'd33:  g = 40'h00005f0000;
         7'd34:  g = 40'h0007000700;
         7'd35:  g = 40'h147f147f14;
         7'd36:  g = 40'h242a7f2a12;
         7'd37:  g = 40'h2313086462;
         7'd38:  g = 40'h3649552250;
         7'd39:  g = 40'h0005030000;
         7'd40:  g = 40'h001c224100;
         7'd41:  g = 40'h0041221c00;
         7'd42:  g = 40'h14083e0814;
         7'd43:  g = 40'h08083e0808;
         7'd44:  g = 40'h0050300000;
         7'd45:  g = 40'h0808080808;
         7'd46:  g = 40'h0060600000;
         7'd47:  g = 40'h2010080402;
         7'd48:  g = 40'h3e5149453e;
         7'd49:  g = 40'h00427f4000;
         7'd50:  g = 40'h4261514946;
         7'd51:  g = 40'h2141454b31;
         7'd52:  g = 40'h1814127f10;
         7'd53:  g = 40'h2745454539;
         7'd54:  g = 40'h3c4a494930;
         7'd55:  g = 40'h0171090503;
         7'd56:  g = 40'h3649494936;
         7'd57:  g = 40'h064949291e;
         7'd58:  g = 40'h0036360000;
         7'd59:  g = 40'h0056360000;
         7'd60:  g = 40'h0814224100;
         7'd61:  g = 40'h1414141414;
         7'd62:  g = 40'h0041221408;
         7'd63:  g = 40'h0201510906;
         7'd64:  g = 40'h324979413e;
         7'd65:  g = 40'h7e1111117e;
         7'd66:  g = 40'h7f49494936;
         7'd67:  g = 40'h3e41414122;
         7'd68:  g = 40'h7f4141221c;
         7'd69:  g = 40'h7f49494941;
         7'd70:  g = 40'h7f09090901;
         7'd71:  g = 40'h3e4149497a;
         7'd72:  g = 40'h7f0808087f;
         7'd73:  g = 40'h00417f4100;
         7'd74:  g = 40'h2040413f01;
         7'd75:  g = 40'h7f08142241;
         7'd76:  g = 40'h7f40404040;
         7'd77:  g = 40'h7f020c027f;
         7'd78:  g = 40'h7f0408107f;
         7'd79:  g = 40'h3e4141413e;
         7'd80:  g = 40'h7f09090906;
         7'd81:  g = 40'h3e4151215e;
         7'd82:  g = 40'h7f09192946;
         7'd83:  g = 40'h4649494931;
         7'd84:  g = 40'h01017f0101;
         7'd85:  g = 40'h3f4040403f;
         7'd86:  g = 40'h1f2040201f;
         7'd87:  g = 40'h3f4038403f;
         7'd88:  g = 40'h6314081463;
         7'd89:  g = 40'h0708700807;
         7'd90:  g = 40'h6151494543;
         7'd91:  g = 40'h007f414100;
         7'd92:  g = 40'h0204081020;
         7'd93:  g = 40'h0041417f00;
         7'd94:  g = 40'h0402010204;
         7'd95:  g = 40'h4040404040;
         7'd96:  g = 40'h0001020400;
         7'd97:  g = 40'h2054545478;
         7'd98:  g = 40'h7f48444438;
         7'd99:  g = 40'h3844444420;
         7'd100: g = 40'h384444487f;
         7'd101: g = 40'h3854545418;
         7'd102: g = 40'h087e090102;
         7'd103: g = 40'h0c5252523e;
         7'd104: g = 40'h7f08040478;
         7'd105: g = 40'h00447d4000;
         7'd106: g = 40'h2040443d00;
         7'd107: g = 40'h7f10284400;
         7'd108: g = 40'h00417f4000;
         7'd109: g = 40'h7c04180478;
         7'd110: g = 40'h7c08040478;
         7'd111: g = 40'h3844444438;
         7'd112: g = 40'h7c14141408;
         7'd113: g = 40'h081414187c;
         7'd114: g = 40'h7c08040408;
         7'd115: g = 40'h4854545420;
         7'd116: g = 40'h043f444020;
         7'd117: g = 40'h3c4040207c;
         7'd118: g = 40'h1c2040201c;
         7'd119: g = 40'h3c4030403c;
         7'd120: g = 40'h4428102844;
         7'd121: g = 40'h0c5050503c;
         7'd122: g = 40'h4464544c44;
         7'd123: g = 40'h0008364100;
         7'd124: g = 40'h00007f0000;
         7'd125: g = 40'h0041360800;
         7'd126: g = 40'h1008081008;
         7'd127: g = 40'h7846414678;
         default: g = 40'h0000000000;   // control codes are blank
      endcase
      return g;
   endfunction

   // Repeat each bit of a glyph byte f times (f in 1..8), bit 0 first
   function automatic logic [63:0] stretch_column(input logic [7:0] g, input logic [3:0] f);
      logic [63:0] acc;
      acc = '0;
      for (int fi = 1; fi <= 8; fi++) begin
         if (f == 4'(fi)) begin
            for (int b = 0; b < 8; b++) begin
               for (int k = 0; k < fi; k++) begin
                  acc[b * fi + k] = g[b];
               end
            end
         end
      end
      return acc;
   endfunction

endpackage

/* rtl/sfcg_front.sv */
// Front end: accepts character requests, holds the scale register and the
// cursor, looks up the glyph and issues one command per character.
// Depends on sfcg_pkg.
module sfcg_front #(
   parameter int MAX_SCALE = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [6:0]           req_char_code,
   input  logic                 req_start_string,
   input  logic [5:0]           req_text_column,
   input  logic [2:0]           req_page,
   // configuration
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [3:0]           csr_scale,
   // command queue push side
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output sfcg_pkg::sfcg_cmd_type cmd_data
);

   logic [3:0] scale_ff, scale_in;
   logic [7:0] cursor_column_ff, cursor_column_in;
   logic [2:0] cursor_page_ff, cursor_page_in;

   logic       accept;
   logic [3:0] scale_eff;
   logic [7:0] start_column;
   logic [7:0] base_column;
   logic [2:0] base_page;
   logic [7:0] advance;

   assign csr_ready = 1'b1;
   assign req_ready = cmd_ready;
   assign accept    = req_valid & cmd_ready;
   assign cmd_valid = req_valid;

   // scale above the maximum acts as the maximum
   assign scale_eff = (scale_ff > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : scale_ff;

   // cursor load on start: text column times six, wrapping
   assign start_column = 8'({2'b00, req_text_column} << 2) + 8'({2'b00, req_text_column} << 1);
   assign base_column  = req_start_string ? start_column : cursor_column_ff;
   assign base_page    = req_start_string ? req_page : cursor_page_ff;

   // cell pitch: 6 native, 5 * scale + 1 otherwise
   assign advance = (scale_eff == 4'd0) ? 8'(sfcg_pkg::CELL_PITCH)
                  : 8'(8'(scale_eff) * 8'(sfcg_pkg::GLYPH_WIDTH) + 8'd1);

   // command build
   always_comb begin
      cmd_data.glyph       = sfcg_pkg::font_glyph(req_char_code);
      cmd_data.base_column = base_column;
      cmd_data.page        = base_page;
      cmd_data.native      = (scale_eff == 4'd0);
      case (scale_eff)
         4'd0: begin
            cmd_data.span = 4'd1;
            cmd_data.reps = 4'd1;
         end
         4'd1: begin
            cmd_data.span = 4'd2;
            cmd_data.reps = 4'd1;
         end
         default: begin
            cmd_data.span = scale_eff;
            cmd_data.reps = scale_eff;
         end
      endcase
   end

   // register next values
   always_comb begin
      scale_in         = scale_ff;
      cursor_column_in = cursor_column_ff;
      cursor_page_in   = cursor_page_ff;
      if (csr_valid) begin
         scale_in = csr_scale;
      end
      if (accept) begin
         cursor_column_in = base_column + advance;
         cursor_page_in   = base_page;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff         <= '0;
         cursor_column_ff <= '0;
         cursor_page_ff   <= '0;
      end else begin
         scale_ff         <= scale_in;
         cursor_column_ff <= cursor_column_in;
         cursor_page_ff   <= cursor_page_in;
      end
   end

endmodule

/* rtl/sfcg_queue.sv */
// Short command queue between front and back ends.
// Depends on sfcg_pkg.
module sfcg_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  sfcg_pkg::sfcg_cmd_type push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output sfcg_pkg::sfcg_cmd_type pop_data
);

   localparam int PTR_W = (sfcg_pkg::QDEPTH > 1) ? $clog2(sfcg_pkg::QDEPTH) : 1;
   localparam int CNT_W = $clog2(sfcg_pkg::QDEPTH + 1);

   sfcg_pkg::sfcg_cmd_type entry_ff [sfcg_pkg::QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(sfcg_pkg::QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(sfcg_pkg::QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(sfcg_pkg::QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/sfcg_back.sv */
// Back end: walks the glyph columns of the head command, stretching pixels,
// one result column per cycle into the response register unless it stalls.
// Depends on sfcg_pkg.
module sfcg_back #(
   parameter int MAX_SCALE = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  sfcg_pkg::sfcg_cmd_type cmd_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_column_address,
   output logic [2:0]             rsp_first_page,
   output logic [3:0]             rsp_page_count,
   output logic [63:0]            rsp_column_bits,
   output logic                   rsp_last_column
);

   localparam int OFS_W = $clog2(sfcg_pkg::GLYPH_WIDTH * MAX_SCALE + 1);
   localparam int REP_W = $clog2(MAX_SCALE);

   logic [2:0]       col_ff, col_in;
   logic [REP_W-1:0] rep_ff, rep_in;
   logic [OFS_W-1:0] ofs_ff, ofs_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       column_address_ff;
   logic [2:0]       first_page_ff;
   logic [3:0]       page_count_ff;
   logic [63:0]      column_bits_ff;
   logic             last_column_ff;

   logic             emit;
   logic             rep_done;
   logic             last;
   logic [7:0]       glyph_byte;

   assign emit      = cmd_valid & (~rsp_valid_ff | rsp_ready);
   assign rep_done  = (4'(rep_ff) == cmd_data.reps - 4'd1);
   assign last      = cmd_data.native ? (col_ff == 3'(sfcg_pkg::GLYPH_WIDTH))
                    : ((col_ff == 3'(sfcg_pkg::GLYPH_WIDTH - 1)) & rep_done);
   assign cmd_ready = emit & last;

   // glyph column select, blank past the fifth column
   always_comb begin
      case (col_ff)
         3'd0:    glyph_byte = cmd_data.glyph[39:32];
         3'd1:    glyph_byte = cmd_data.glyph[31:24];
         3'd2:    glyph_byte = cmd_data.glyph[23:16];
         3'd3:    glyph_byte = cmd_data.glyph[15:8];
         3'd4:    glyph_byte = cmd_data.glyph[7:0];
         default: glyph_byte = 8'h00;
      endcase
   end

   // column walk counters
   always_comb begin
      col_in = col_ff;
      rep_in = rep_ff;
      ofs_in = ofs_ff;
      if (emit) begin
         if (last) begin
            col_in = '0;
            rep_in = '0;
            ofs_in = '0;
         end else begin
            ofs_in = ofs_ff + 1'b1;
            if (cmd_data.native | rep_done) begin
               col_in = col_ff + 1'b1;
               rep_in = '0;
            end else begin
               rep_in = rep_ff + 1'b1;
            end
         end
      end
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         rep_ff       <= '0;
         ofs_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         rep_ff       <= rep_in;
         ofs_ff       <= ofs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (emit) begin
         column_address_ff <= cmd_data.base_column + 8'(ofs_ff);
         first_page_ff     <= cmd_data.page;
         page_count_ff     <= cmd_data.span;
         column_bits_ff    <= sfcg_pkg::stretch_column(glyph_byte, cmd_data.span);
         last_column_ff    <= last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_column_address = column_address_ff;
   assign rsp_first_page     = first_page_ff;
   assign rsp_page_count     = page_count_ff;
   assign rsp_column_bits    = column_bits_ff;
   assign rsp_last_column    = last_column_ff;

endmodule

/* rtl/scaled_font_character_generator_unit.sv */
// Top level of the scaled font character generator.
// Instantiates sfcg_front, sfcg_queue and sfcg_back; uses sfcg_pkg.
//
//   Channel  Direction  Handshake        Payload
//   req_     in         valid / ready    char_code, start_string, text_column, page
//   rsp_     out        valid / ready    column_address, first_page, page_count,
//                                        column_bits, last_column (one per column)
//   csr_     in         valid / ready    scale (ready is always high)
//
// Columns: the back end emits one column per cycle unless the response stalls;
// a character is 6 columns at scale 0, 5 at scale 1, 5 * scale at 2..MAX_SCALE (40 at 8).
// The front end takes a request whenever the two-entry queue has room.
// Reset clears scale, cursor, queue and the output register valid.
// A stalled response holds the back end; the front end keeps filling the queue.
module scaled_font_character_generator_unit #(
   parameter int MAX_SCALE = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [6:0]  req_char_code,
   input  logic        req_start_string,
   input  logic [5:0]  req_text_column,
   input  logic [2:0]  req_page,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_column_address,
   output logic [2:0]  rsp_first_page,
   output logic [3:0]  rsp_page_count,
   output logic [63:0] rsp_column_bits,
   output logic        rsp_last_column,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_scale
);

   logic                   push_valid, push_ready;
   logic                   pop_valid, pop_ready;
   sfcg_pkg::sfcg_cmd_type push_data, pop_data;

   // request intake and classification
   sfcg_front #(
      .MAX_SCALE (MAX_SCALE)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_start_string (req_start_string),
      .req_text_column  (req_text_column),
      .req_page         (req_page),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_scale        (csr_scale),
      .cmd_valid        (push_valid),
      .cmd_ready        (push_ready),
      .cmd_data         (push_data)
   );

   // decoupling queue
   sfcg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // column generation
   sfcg_back #(
      .MAX_SCALE (MAX_SCALE)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (pop_valid),
      .cmd_ready          (pop_ready),
      .cmd_data           (pop_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_column_address (rsp_column_address),
      .rsp_first_page     (rsp_first_page),
      .rsp_page_count     (rsp_page_count),
      .rsp_column_bits    (rsp_column_bits),
      .rsp_last_column    (rsp_last_column)
   );

endmodule

/* tb/tb.sv */
// Testbench for scaled_font_character_generator_unit: directed and random character
// requests under fixed and random scales, with a self-contained glyph/column predictor.
// Depends on rtl/sfcg_pkg.sv and rtl/scaled_font_character_generator_unit.sv.
`timescale 1ns / 1ps

module tb;

   localparam int GLYPH_WIDTH  = sfcg_pkg::GLYPH_WIDTH;
   localparam int CELL_PITCH   = sfcg_pkg::CELL_PITCH;
   localparam int MAX_SCALE    = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_TAIL    = 4;
   localparam int END_TAIL     = 64;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 32;
   localparam int MAX_PRINTS   = 40;

   // one display column as the block should emit it
   typedef struct packed {
      logic [7:0]  address;
      logic [2:0]  first_page;
      logic [3:0]  pages;
      logic [63:0] bits;
      logic        last;
   } column_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [6:0]  req_char_code    = '0;
   logic        req_start_string = 1'b0;
   logic [5:0]  req_text_column  = '0;
   logic [2:0]  req_page         = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [7:0]  rsp_column_address;
   logic [2:0]  rsp_first_page;
   logic [3:0]  rsp_page_count;
   logic [63:0] rsp_column_bits;
   logic        rsp_last_column;
   logic        csr_valid        = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_scale        = '0;

   // predictor state
   logic [3:0]  scale_setting = '0;
   logic [7:0]  cursor_col    = '0;
   logic [2:0]  cursor_pg     = '0;
   column_type  pending_columns[$];
   column_type  oldest;

   int          fail_count  = 0;
   int          cycle_count = 0;
   int          burst_left  = 0;
   int          hold_asked  = 0;
   int          hold_served = 0;
   int          hold_left   = 0;
   int          rsp_mode    = 0;
   int          mode_timer  = 0;

   // glyph columns, column 0 in bits 39:32
   logic [39:0] glyph_rom [0:127] = '{
      40'hffffffffff, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0,
      40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0,
      40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0,
      40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0, 40'h0,
      40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
      40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
      40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
      40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
      40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
      40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
      40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
      40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
      40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
      40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
      40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
      40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h7846414678
   };

   scaled_font_character_generator_unit #(.MAX_SCALE(MAX_SCALE)) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_code      (req_char_code),
      .req_start_string   (req_start_string),
      .req_text_column    (req_text_column),
      .req_page           (req_page),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_column_address (rsp_column_address),
      .rsp_first_page     (rsp_first_page),
      .rsp_page_count     (rsp_page_count),
      .rsp_column_bits    (rsp_column_bits),
      .rsp_last_column    (rsp_last_column),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_scale          (csr_scale)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // each pixel of a glyph byte repeated factor times, bit 0 first
   function automatic logic [63:0] repeat_pixels(input logic [7:0] g, input int factor);
      logic [63:0] acc;
      acc = '0;
      for (int b = 0; b < 8; b++)
         for (int k = 0; k < factor; k++)
            acc[b * factor + k] = g[b];
      return acc;
   endfunction

   // expected columns of one character request, advances the cursor
   function automatic void draw_character(input logic [6:0] code, input logic start,
                                          input logic [5:0] tcol, input logic [2:0] pg);
      int      eff;
      int      span;
      int      reps;
      int      n;
      logic [7:0] gbyte;
      column_type col;
      if (start) begin
         cursor_col = 8'(int'(tcol) * CELL_PITCH);
         cursor_pg  = pg;
      end
      eff = (scale_setting > MAX_SCALE) ? MAX_SCALE : int'(scale_setting);
      n = 0;
      if (eff == 0) begin
         // native: five glyph columns, then the blank spacing column
         for (int c = 0; c < GLYPH_WIDTH; c++) begin
            col.address    = cursor_col + 8'(c);
            col.first_page = cursor_pg;
            col.pages      = 4'd1;
            col.bits       = {56'd0, glyph_rom[code][39 - 8 * c -: 8]};
            col.last       = 1'b0;
            pending_columns.push_back(col);
         end
         col.address = cursor_col + 8'(GLYPH_WIDTH);
         col.bits    = '0;
         col.last    = 1'b1;
         pending_columns.push_back(col);
         cursor_col = cursor_col + 8'(GLYPH_WIDTH + 1);
      end else begin
         span = (eff == 1) ? 2 : eff;
         reps = (eff == 1) ? 1 : eff;
         for (int c = 0; c < GLYPH_WIDTH; c++) begin
            gbyte = glyph_rom[code][39 - 8 * c -: 8];
            for (int r = 0; r < reps; r++) begin
               col.address    = cursor_col + 8'(n);
               col.first_page = cursor_pg;
               col.pages      = 4'(span);
               col.bits       = repeat_pixels(gbyte, span);
               col.last       = (c == GLYPH_WIDTH - 1) && (r == reps - 1);
               pending_columns.push_back(col);
               n++;
            end
         end
         cursor_col = cursor_col + 8'(eff * GLYPH_WIDTH + 1);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want_v,
                                  input logic [63:0] got_v);
      fail_count++;
      if (fail_count <= MAX_PRINTS)
         $display("mismatch %s: expected %h got %h at cycle %0d",
                  what, want_v, got_v, cycle_count);
   endtask

   // column checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_columns.size() == 0) begin
            report_mismatch("column with none expected", 64'd0, {56'd0, rsp_column_address});
         end else begin
            oldest = pending_columns.pop_front();
            if (rsp_column_address !== oldest.address)
               report_mismatch("column_address", oldest.address, rsp_column_address);
            if (rsp_first_page !== oldest.first_page)
               report_mismatch("first_page", oldest.first_page, rsp_first_page);
            if (rsp_page_count !== oldest.pages)
               report_mismatch("page_count", oldest.pages, rsp_page_count);
            if (rsp_column_bits !== oldest.bits)
               report_mismatch("column_bits", oldest.bits, rsp_column_bits);
            if (rsp_last_column !== oldest.last)
               report_mismatch("last_column", oldest.last, rsp_last_column);
         end
      end
   end

   // receiver: stall pattern that changes mode every so often, plus long holds on demand
   always @(posedge clock) begin
      if (mode_timer == 0) begin
         rsp_mode   <= $urandom_range(0, 3);
         mode_timer <= $urandom_range(20, 120);
      end else begin
         mode_timer <= mode_timer - 1;
      end
      if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (rsp_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (mode_timer % 5 > 1);
         endcase
      end
   end

   // one request; valid stays up afterwards until the caller sends again or pauses
   task automatic send_char(input logic [6:0] code, input logic start,
                            input logic [5:0] tcol, input logic [2:0] pg);
      req_valid        <= 1'b1;
      req_char_code    <= code;
      req_start_string <= start;
      req_text_column  <= tcol;
      req_page         <= pg;
      do @(posedge clock); while (!req_ready);
      draw_character(code, start, tcol, pg);
   endtask

   task automatic pause(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // bursts of requests separated by random gaps
   task automatic pace_sender();
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
         pause(($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6));
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_columns.size() != 0);
      repeat (IDLE_TAIL) @(posedge clock);
   endtask

   task automatic write_scale(input logic [3:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_scale <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      scale_setting = value;
   endtask

   // scale 0 straight out of reset; fields other than the code ignored without start
   task automatic test_reset_state();
      send_char(7'd65, 1'b0, 6'd0, 3'd0);
      send_char(7'd0, 1'b0, 6'h3f, 3'd7);
   endtask

   // native columns with blank spacing, field extremes, control code
   task automatic test_native_columns();
      send_char(7'd127, 1'b1, 6'd0, 3'd0);
      send_char(7'd1, 1'b1, 6'd42, 3'd7);
      send_char(7'd32, 1'b0, 6'd21, 3'd2);
   endtask

   // text column past the display and column address wrapping past 255
   task automatic test_column_wrap();
      send_char(7'd72, 1'b1, 6'd63, 3'd5);
      send_char(7'd87, 1'b1, 6'd42, 3'd3);
      send_char(7'd126, 1'b0, 6'd0, 3'd0);
   endtask

   task automatic test_double_height();
      write_scale(4'd1);
      send_char(7'd0, 1'b1, 6'd10, 3'd6);
      send_char(7'd77, 1'b0, 6'd0, 3'd0);
   endtask

   // square scaling, largest scale, and values above the maximum
   task automatic test_square_scaling();
      write_scale(4'd2);
      send_char(7'd48, 1'b1, 6'd0, 3'd1);
      write_scale(4'd8);
      send_char(7'd0, 1'b1, 6'd40, 3'd0);
      send_char(7'd65, 1'b0, 6'd0, 3'd0);
      write_scale(4'd9);
      send_char(7'd66, 1'b1, 6'd42, 3'd7);
      write_scale(4'd15);
      send_char(7'd127, 1'b1, 6'd63, 3'd4);
      send_char(7'd1, 1'b0, 6'd0, 3'd0);
   endtask

   // long receiver hold at the largest scale so the queue fills and input stalls
   task automatic test_full_queue();
      write_scale(4'd8);
      hold_asked++;
      for (int i = 0; i < 6; i++)
         send_char(7'($urandom_range(32, 126)), (i == 0), 6'($urandom_range(0, 63)),
                   3'($urandom_range(0, 7)));
   endtask

   // strings of characters: a start request then continuation characters
   task automatic test_random_strings();
      int sent;
      int len;
      logic [6:0] code;
      logic start;
      for (int p = 0; p < PHASES; p++) begin
         if (p == 0)
            write_scale(4'd0);
         else if (p == 1)
            write_scale(4'd8);
         else
            write_scale(4'($urandom_range(0, 15)));
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len && sent < PHASE_ITEMS; i++) begin
               code  = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(32, 126));
               start = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0);
               send_char(code, start, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)));
               pace_sender();
               sent++;
            end
         end
      end
   endtask

   initial begin
      int waited;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_native_columns();
      test_column_wrap();
      test_double_height();
      test_square_scaling();
      test_full_queue();
      test_random_strings();

      // drain and settle
      req_valid <= 1'b0;
      waited = 0;
      while (pending_columns.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (END_TAIL) @(posedge clock);
      if (pending_columns.size() != 0)
         report_mismatch("columns never produced", 64'(pending_columns.size()), 64'd0);
      if (fail_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
